// File: rtl/core/gcl_pkg.sv
// gcl_pkg: shared types and codes for the glyph coverage lookup block.
// Request and result payload structs, table entry layout, register and
// format codes. No dependencies.
`timescale 1ns / 1ps

package gcl_pkg;

  // Request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Coverage table formats
  localparam logic [15:0] FMT_LIST  = 16'd1;
  localparam logic [15:0] FMT_RANGE = 16'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT  = 1'b1;

  localparam int COUNT_W = 9;
  localparam int INDEX_W = 17;

  // One request item
  typedef struct packed {
    logic        func;
    logic [7:0]  entry_index;
    logic [15:0] glyph;
    logic [15:0] range_end;
    logic [15:0] range_base;
  } gcl_in_t;

  // One result item
  typedef struct packed {
    logic               covered;
    logic [INDEX_W-1:0] coverage_index;
  } gcl_out_t;

  // Stored table entry: start/glyph, range end, range base
  typedef struct packed {
    logic [15:0] start_g;
    logic [15:0] end_g;
    logic [15:0] base;
  } gcl_entry_t;

  // Match unit answer
  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] idx;
  } gcl_match_t;

endpackage

// File: rtl/core/gcl_match_unit.sv
// gcl_match_unit: compares one table entry against the looked-up glyph.
// Shared by every step of a scan. Depends on gcl_pkg.
`timescale 1ns / 1ps

module gcl_match_unit #(
  parameter int POS_W = 8
) (
  input  logic                  fmt_range,
  input  gcl_pkg::gcl_entry_t   entry,
  input  logic [15:0]           glyph,
  input  logic [POS_W-1:0]      pos,
  output gcl_pkg::gcl_match_t   result
);

  logic [15:0] offset;

  // Offset from range start; only meaningful when glyph >= start
  assign offset = glyph - entry.start_g;

  always_comb begin
    if (fmt_range) begin
      result.hit = (glyph >= entry.start_g) && (glyph <= entry.end_g);
      result.idx = {1'b0, entry.base} + {1'b0, offset};
    end else begin
      result.hit = (glyph == entry.start_g);
      result.idx = gcl_pkg::INDEX_W'(pos);
    end
  end

endmodule

// File: rtl/core/glyph_coverage_lookup.sv
// glyph_coverage_lookup: coverage table store and sequential lookup engine.
// Depends on gcl_pkg and gcl_match_unit.
`timescale 1ns / 1ps
//
// Usage:
//   Requests enter on in_data when start is high and busy is low.
//   A load request (func 0) writes one table slot and gives no result;
//   slots at or beyond ENTRIES are dropped.
//   A lookup request (func 1) scans slots 0 .. min(entry_count, ENTRIES)-1
//   in order, one slot per cycle through a single compare/add unit fed by
//   the table memory's registered read port, and stops at the first match.
//   Busy is high while a lookup scans.
//   An empty scan or an unknown format answers in the cycle after the request.
//   The result appears on out_data for exactly one cycle with out_valid;
//   the receiver cannot stall, so nothing backs up.
//   Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at once;
//   the user must issue them only while the block is idle; it does not check.
//   Reset sets format 1 and entry count 0; the table contents are
//   undefined until loaded and need no clearing pass.
//
module glyph_coverage_lookup #(
  parameter int ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gcl_pkg::gcl_in_t              in_data,
  output logic                          out_valid,
  output gcl_pkg::gcl_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [gcl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EXT_W = (IDX_W > 8) ? IDX_W : 8;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  logic [15:0]                    fmt_r;
  logic [gcl_pkg::COUNT_W-1:0]    count_r;
  logic [CNT_W-1:0]               ptr_r, ptr_nxt;
  logic [CNT_W-1:0]               limit_r, limit_nxt;
  logic [IDX_W-1:0]               pos_r, pos_nxt;
  logic [15:0]                    glyph_r, glyph_nxt;
  logic                           fmt2_r, fmt2_nxt;
  logic                           out_valid_r, out_valid_nxt;
  gcl_pkg::gcl_out_t              out_data_r, out_data_nxt;

  gcl_pkg::gcl_entry_t            mem [ENTRIES];
  gcl_pkg::gcl_entry_t            rd_data_r;
  gcl_pkg::gcl_entry_t            wr_entry;
  gcl_pkg::gcl_match_t            match;

  logic                           accept;
  logic                           do_load;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic [EXT_W-1:0]               load_idx;
  logic [CNT_W-1:0]               scan_n;
  logic                           fmt_ok;

  assign accept   = start && (state_r == S_IDLE);
  assign load_idx = EXT_W'(in_data.entry_index);
  assign do_load  = accept && (in_data.func == gcl_pkg::FUNC_LOAD) &&
                    (32'(in_data.entry_index) < ENTRIES);
  assign fmt_ok   = (fmt_r == gcl_pkg::FMT_LIST) || (fmt_r == gcl_pkg::FMT_RANGE);
  assign scan_n   = (32'(count_r) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(count_r);

  assign wr_entry.start_g = in_data.glyph;
  assign wr_entry.end_g   = in_data.range_end;
  assign wr_entry.base    = in_data.range_base;

  // Table memory: one write port for loads, one registered read for scans
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[load_idx[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Shared compare unit
  gcl_match_unit #(
    .POS_W (IDX_W)
  ) u_match (
    .fmt_range (fmt2_r),
    .entry     (rd_data_r),
    .glyph     (glyph_r),
    .pos       (pos_r),
    .result    (match)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= gcl_pkg::FMT_LIST;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gcl_pkg::REG_FORMAT: fmt_r   <= cfg_wdata;
        gcl_pkg::REG_COUNT:  count_r <= cfg_wdata[gcl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan sequencer
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    limit_nxt     = limit_r;
    pos_nxt       = pos_r;
    glyph_nxt     = glyph_r;
    fmt2_nxt      = fmt2_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.func == gcl_pkg::FUNC_LOOKUP)) begin
          glyph_nxt = in_data.glyph;
          fmt2_nxt  = (fmt_r == gcl_pkg::FMT_RANGE);
          limit_nxt = scan_n;
          if (fmt_ok && (scan_n != '0)) begin
            // first slot read issued now
            rd_en     = 1'b1;
            rd_addr   = '0;
            pos_nxt   = '0;
            ptr_nxt   = CNT_W'(1);
            state_nxt = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        if (match.hit) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.covered        = 1'b1;
          out_data_nxt.coverage_index = match.idx;
          state_nxt                   = S_IDLE;
        end else if (ptr_r < limit_r) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r[IDX_W-1:0];
          pos_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    limit_r    <= limit_nxt;
    pos_r      <= pos_nxt;
    glyph_r    <= glyph_nxt;
    fmt2_r     <= fmt2_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/gcl_checker.sv
// gcl_checker: port-level assertions for glyph_coverage_lookup, with bind.
// Depends on gcl_pkg and the top level's ports.
`timescale 1ns / 1ps

module gcl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input gcl_pkg::gcl_in_t  in_data,
  input logic              out_valid,
  input gcl_pkg::gcl_out_t out_data
);

  // A miss never carries an index
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.covered) |-> (out_data.coverage_index == '0))
    else $error("not-covered result with nonzero index");

  // Results come out only once the scan is over
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A load request gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.func == gcl_pkg::FUNC_LOAD)) |=> !out_valid)
    else $error("result after a load request");

  // A scan only starts from an accepted lookup request
  a_scan_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_data.func == gcl_pkg::FUNC_LOOKUP)))
    else $error("busy without a lookup request");

endmodule

bind glyph_coverage_lookup gcl_checker u_gcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
